// File: rtl/dgsp_pkg.sv
// shared types, constants and helpers for the dense graph shortest path block
package dgsp_pkg;

  localparam int MAX_NODES = 64;
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = 2 * NW;

  localparam int NODE_W = 7;
  localparam int WEIGHT_W = 31;
  localparam int EW = WEIGHT_W + 1;
  localparam int DIST_W = 38;
  localparam int OUT_DIST_W = 37;
  localparam int CFG_IDX_W = 2;

  localparam int S_TDATA_W = 48;
  localparam int S_PAD_W = S_TDATA_W - 2 * NODE_W - WEIGHT_W;
  localparam int M_TDATA_W = 40;
  localparam int M_PAD_W = M_TDATA_W - OUT_DIST_W;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [NW-1:0] idx_t;
  typedef logic [EW-1:0] edge_w_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam edge_w_t WEIGHT_INF = '1;
  localparam dist_t DIST_INF = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_NODE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EDGE_AB,
    S_EDGE_BA,
    S_INIT,
    S_SCAN,
    S_RELAX,
    S_READ_TGT,
    S_TGT,
    S_BAD
  } state_t;

  typedef struct packed {
    logic  upd;
    dist_t cand;
  } relax_t;

  // node numbers run from one; true when v lies in 1..limit
  function automatic logic node_ok(input node_t v, input int limit);
    node_ok = (v != '0) && (int'(v) <= limit);
  endfunction

  function automatic idx_t node_idx(input node_t v);
    node_idx = NW'(v - NODE_W'(1));
  endfunction

endpackage

// File: rtl/dgsp_relax.sv
// edge relaxation: candidate distance through the settled node and update decision
module dgsp_relax (
  input  dgsp_pkg::dist_t   low,
  input  dgsp_pkg::edge_w_t w,
  input  dgsp_pkg::dist_t   cur,
  input  logic              cur_valid,
  input  logic              done_j,
  output dgsp_pkg::relax_t  res
);
  import dgsp_pkg::*;

  dist_t cand;

  assign cand = low + DIST_W'(w);

  always_comb begin
    res.cand = cand;
    res.upd  = !done_j && (w != WEIGHT_INF) && (!cur_valid || (cand < cur));
  end

endmodule

// File: rtl/dense_graph_shortest_path_top.sv
// top level of the dense graph shortest path block
//
// edges arrive one per transaction on the s_ channel: s_tdata holds end_a,
// end_b and weight, s_tlast marks the final edge of a graph. every edge with both
// ends in 1..64 is folded into a 64 x 64 weight matrix memory (keeping the smaller
// weight, both directions) by a read-modify-write; out of range edges are dropped.
// after the final edge a dijkstra search runs from source_node over nodes
// 1..node_count (at most 64): each round is a scan over the distance memory to pick the
// nearest unsettled node, then a relax pass over that node's matrix row.
// one result transaction follows on the m_ channel: distance in m_tdata,
// reachable in m_tuser. unreachable targets and out of range source or target
// give reachable 0 and distance 0.
// after reset and after each result a clearing pass writes infinity into all
// 4096 matrix entries, one per cycle; s_tready stays low during the pass.
// the result sits in an output register; a stalled receiver only holds the
// result, the clearing pass and then the next graph's edges proceed meanwhile.
// configuration writes (cfg_index 0 node_count, 1 source_node, 2 target_node)
// are always taken and are meant to happen while the block is idle.
module dense_graph_shortest_path_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // edge input: [6:0] end_a, [13:7] end_b, [44:14] weight, rest zero
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [dgsp_pkg::S_TDATA_W-1:0]       s_tdata,
  input  logic                                 s_tlast,
  // result output: [36:0] distance, rest zero
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [dgsp_pkg::M_TDATA_W-1:0]       m_tdata,
  // [0] reachable
  output logic                                 m_tuser,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dgsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dgsp_pkg::NODE_W-1:0]          cfg_data
);
  import dgsp_pkg::*;

  localparam int MEM_DEPTH = 1 << ADDR_W;

  // configuration registers
  node_t node_count;
  node_t source_node;
  node_t target_node;

  state_t state, state_next;

  // matrix memory and distance memory
  edge_w_t wmem [MEM_DEPTH];
  dist_t   dmem [MAX_NODES];

  logic               w_we;
  logic [ADDR_W-1:0]  w_waddr, w_raddr;
  edge_w_t            w_wdata, w_rdata;
  logic               d_we;
  idx_t               d_waddr, d_raddr;
  dist_t              d_wdata, d_rdata;

  // latched edge
  idx_t                e_a, e_b;
  logic [WEIGHT_W-1:0] e_w;
  logic                e_last;
  edge_w_t             w_min;

  // search state
  logic [ADDR_W-1:0]   clr_addr;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       n_eff;
  idx_t                cnt_idx;
  logic                issue;
  logic                p_valid;
  idx_t                p_idx;
  dist_t               low;
  idx_t                pick;
  logic                found;
  logic [MAX_NODES-1:0] settled;
  logic [MAX_NODES-1:0] dvalid;
  logic                pass_done;
  logic                search_ok;
  idx_t                src_idx, tgt_idx;
  relax_t              relax;

  // incoming edge
  node_t               in_a, in_b;
  logic                in_ok;

  // output register
  logic                   out_free;
  logic                   load_out;
  logic [OUT_DIST_W-1:0]  res_dist, dist_out;
  logic                   res_reach;

  assign cfg_ready = 1'b1;

  assign in_a  = s_tdata[NODE_W-1:0];
  assign in_b  = s_tdata[2*NODE_W-1:NODE_W];
  assign in_ok = node_ok(in_a, MAX_NODES) && node_ok(in_b, MAX_NODES);

  // node counts above the matrix size act as the matrix size
  assign n_eff = (int'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);

  assign search_ok = node_ok(source_node, int'(n_eff)) && node_ok(target_node, int'(n_eff));
  assign src_idx   = node_idx(source_node);
  assign tgt_idx   = node_idx(target_node);
  assign cnt_idx   = cnt[NW-1:0];
  assign pass_done = !issue && !p_valid;
  assign out_free  = !m_tvalid || m_tready;

  assign w_min = ({1'b0, e_w} < w_rdata) ? {1'b0, e_w} : w_rdata;

  assign m_tdata = {{M_PAD_W{1'b0}}, dist_out};

  dgsp_relax u_relax (
    .low       (low),
    .w         (w_rdata),
    .cur       (d_rdata),
    .cur_valid (dvalid[p_idx]),
    .done_j    (settled[p_idx]),
    .res       (relax)
  );

  // memories, registered read
  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    d_rdata <= dmem[d_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    w_we       = 1'b0;
    w_waddr    = clr_addr;
    w_wdata    = WEIGHT_INF;
    w_raddr    = {e_a, e_b};
    d_we       = 1'b0;
    d_waddr    = p_idx;
    d_wdata    = relax.cand;
    d_raddr    = cnt_idx;
    issue      = 1'b0;
    load_out   = 1'b0;
    res_dist   = '0;
    res_reach  = 1'b0;
    case (state)
      S_CLEAR: begin
        w_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        w_raddr  = {node_idx(in_a), node_idx(in_b)};
        if (s_tvalid) begin
          if (in_ok) begin
            state_next = S_EDGE_AB;
          end else if (s_tlast) begin
            state_next = search_ok ? S_INIT : S_BAD;
          end
        end
      end
      S_EDGE_AB: begin
        w_we       = 1'b1;
        w_waddr    = {e_a, e_b};
        w_wdata    = w_min;
        w_raddr    = {e_b, e_a};
        state_next = S_EDGE_BA;
      end
      S_EDGE_BA: begin
        w_we    = 1'b1;
        w_waddr = {e_b, e_a};
        w_wdata = w_min;
        if (e_last) begin
          state_next = search_ok ? S_INIT : S_BAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_INIT: begin
        d_we       = 1'b1;
        d_waddr    = src_idx;
        d_wdata    = '0;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        issue = (cnt < n_eff);
        if (pass_done) begin
          state_next = found ? S_RELAX : S_READ_TGT;
        end
      end
      S_RELAX: begin
        issue   = (cnt < n_eff);
        w_raddr = {pick, cnt_idx};
        d_we    = p_valid && relax.upd;
        if (pass_done) begin
          state_next = S_SCAN;
        end
      end
      S_READ_TGT: begin
        d_raddr    = tgt_idx;
        state_next = S_TGT;
      end
      S_TGT: begin
        d_raddr = tgt_idx;
        if (out_free) begin
          load_out   = 1'b1;
          res_reach  = dvalid[tgt_idx];
          res_dist   = dvalid[tgt_idx] ? d_rdata[OUT_DIST_W-1:0] : '0;
          state_next = S_CLEAR;
        end
      end
      S_BAD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_CLEAR;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      cnt         <= '0;
      p_valid     <= 1'b0;
      found       <= 1'b0;
      settled     <= '0;
      dvalid      <= '0;
      m_tvalid    <= 1'b0;
      node_count  <= NODE_W'(64);
      source_node <= NODE_W'(1);
      target_node <= NODE_W'(1);
    end else begin
      p_valid <= issue;
      p_idx   <= cnt_idx;
      if (issue) begin
        cnt <= cnt + CW'(1);
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == S_IDLE && s_tvalid) begin
        e_a    <= node_idx(in_a);
        e_b    <= node_idx(in_b);
        e_w    <= s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
        e_last <= s_tlast;
      end
      if (state == S_INIT) begin
        settled          <= '0;
        // only the source distance is known at the start
        dvalid           <= MAX_NODES'(1) << src_idx;
        cnt              <= '0;
        low              <= DIST_INF;
        found            <= 1'b0;
      end
      if (state == S_SCAN) begin
        // nearest unsettled node with a known distance, first one wins ties
        if (p_valid && !settled[p_idx] && dvalid[p_idx] && (d_rdata < low)) begin
          low   <= d_rdata;
          pick  <= p_idx;
          found <= 1'b1;
        end
        if (pass_done && found) begin
          settled[pick] <= 1'b1;
          cnt           <= '0;
        end
      end
      if (state == S_RELAX) begin
        if (p_valid && relax.upd) begin
          dvalid[p_idx] <= 1'b1;
        end
        if (pass_done) begin
          cnt   <= '0;
          low   <= DIST_INF;
          found <= 1'b0;
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_NODE_COUNT:  node_count  <= cfg_data;
          CFG_SOURCE_NODE: source_node <= cfg_data;
          CFG_TARGET_NODE: target_node <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (load_out) begin
      dist_out <= res_dist;
      m_tuser  <= res_reach;
    end
  end

endmodule

// File: rtl/dgsp_check.sv
// port-level checks for the dense graph shortest path block, bound to the top level
module dgsp_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tlast,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [dgsp_pkg::M_TDATA_W-1:0]    m_tdata,
  input logic                              m_tuser
);
  import dgsp_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an unreachable result carries zero distance
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("unreachable result with nonzero distance");

  // the clearing pass follows reset, so no edge is taken right after it
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("edge taken during clearing pass");

  // the final edge ends the graph's intake, so no edge is taken right after it
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("edge taken right after the final edge");

endmodule

bind dense_graph_shortest_path_top dgsp_check u_dgsp_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
